// ===== hdl/sna_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the spline news ACD filter.
package sna_pkg;

  localparam int MAX_KNOTS_DEF     = 16;
  localparam int MAX_NEWS_LAGS_DEF = 8;
  localparam int MAX_MEAN_LAGS_DEF = 8;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int PADDR_W           = 5;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PRIME = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_SLOPE = 2'd0,
    SEL_BREAK = 2'd1,
    SEL_LAGW  = 2'd2,
    SEL_MEANW = 2'd3
  } sel_e;

  typedef enum logic [2:0] {
    REG_BASE_LEVEL    = 3'd0,
    REG_BURN_LENGTH   = 3'd1,
    REG_TOTAL_SAMPLES = 3'd2,
    REG_KNOTS_USED    = 3'd3,
    REG_NEWS_LAGS     = 3'd4,
    REG_MEAN_LAGS     = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LAG_START,
    ST_S0_WAIT,
    ST_MUL,
    ST_RND,
    ST_NEWS0_DONE,
    ST_KNOT_TEST,
    ST_BP_WAIT,
    ST_SLOPE_WAIT,
    ST_NEWS_K_DONE,
    ST_LAG_W,
    ST_LW_WAIT,
    ST_LAG_DONE,
    ST_MEAN_START,
    ST_MW_WAIT,
    ST_MEAN_DONE,
    ST_FINAL,
    ST_DUR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [31:0] base_level;
    logic [31:0]        burn_length;
    logic [31:0]        total_samples;
    logic [4:0]         knots_used;
    logic [3:0]         news_lags;
    logic [3:0]         mean_lags;
  } cfg_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } satval_t;

  function automatic satval_t sat_to32(input logic signed [65:0] v);
    satval_t r;
    if (v > 66'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic satval_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat_to32(66'(a) + 66'(b));
  endfunction

  function automatic satval_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat_to32(66'(a) - 66'(b));
  endfunction

endpackage

// ===== hdl/sna_ifs.sv =====
// Valid/ready channel interfaces for the input items and the result words.
interface sna_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         table_select;
  logic [4:0]         table_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] innovation;
  logic signed [31:0] start_mu;
  logic signed [31:0] start_x;

  modport source (output valid, command, table_select, table_index, coef_value, innovation,
                  start_mu, start_x, input ready);
  modport sink (input valid, command, table_select, table_index, coef_value, innovation,
                start_mu, start_x, output ready);
endinterface

interface sna_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] duration;
  logic               saturated;
  logic               last;

  modport source (output valid, duration, saturated, last, input ready);
  modport sink (input valid, duration, saturated, last, output ready);
endinterface

// ===== hdl/sna_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sna_regs.sv =====
// APB-style configuration register file.
module sna_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sna_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sna_pkg::cfg_t               cfg
);
  import sna_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_level    <= '0;
      cfg.burn_length   <= '0;
      cfg.total_samples <= '0;
      cfg.knots_used    <= '0;
      cfg.news_lags     <= 4'd1;
      cfg.mean_lags     <= '0;
    end else if (wr_en) begin
      unique case (reg_e'(paddr[4:2]))
        REG_BASE_LEVEL:    cfg.base_level    <= pwdata;
        REG_BURN_LENGTH:   cfg.burn_length   <= pwdata;
        REG_TOTAL_SAMPLES: cfg.total_samples <= pwdata;
        REG_KNOTS_USED:    cfg.knots_used    <= pwdata[4:0];
        REG_NEWS_LAGS:     cfg.news_lags     <= pwdata[3:0];
        REG_MEAN_LAGS:     cfg.mean_lags     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[4:2]))
      REG_BASE_LEVEL:    prdata = cfg.base_level;
      REG_BURN_LENGTH:   prdata = cfg.burn_length;
      REG_TOTAL_SAMPLES: prdata = cfg.total_samples;
      REG_KNOTS_USED:    prdata = {27'd0, cfg.knots_used};
      REG_NEWS_LAGS:     prdata = {28'd0, cfg.news_lags};
      REG_MEAN_LAGS:     prdata = {28'd0, cfg.mean_lags};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/sna_core.sv =====
// Sequencer and shared-multiplier datapath over the coefficient RAM and the histories.
module sna_core #(
  parameter int MAX_KNOTS     = sna_pkg::MAX_KNOTS_DEF,
  parameter int MAX_NEWS_LAGS = sna_pkg::MAX_NEWS_LAGS_DEF,
  parameter int MAX_MEAN_LAGS = sna_pkg::MAX_MEAN_LAGS_DEF,
  parameter int FRAC_BITS     = sna_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sna_pkg::cfg_t cfg,
  sna_in_if.sink        in_ch,
  sna_out_if.source     out_ch
);
  import sna_pkg::*;

  localparam int IW    = $clog2((MAX_KNOTS + 1 > 32) ? MAX_KNOTS + 1 : 32);
  localparam int AW    = IW + 2;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(MAX_KNOTS + 2);
  localparam int MAXL  = (MAX_NEWS_LAGS > MAX_MEAN_LAGS) ? MAX_NEWS_LAGS : MAX_MEAN_LAGS;
  localparam int LW    = $clog2(MAXL + 1);
  localparam int MH_D  = (MAX_MEAN_LAGS > 0) ? MAX_MEAN_LAGS : 1;
  localparam int EHW   = (MAX_NEWS_LAGS > 1) ? $clog2(MAX_NEWS_LAGS) : 1;
  localparam int MHW   = (MH_D > 1) ? $clog2(MH_D) : 1;

  state_e state, state_next, ret;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic signed [31:0] rdata;
  logic               wr_ok;
  logic               accept;

  logic signed [31:0] ehist [MAX_NEWS_LAGS];
  logic signed [31:0] mhist [MH_D];
  logic [31:0]        sample_cnt;

  logic signed [31:0] x, acc, mu, mul_a, mul_b, mres, e_reg, dur;
  logic signed [63:0] prod;
  logic [LW-1:0]      j;
  logic [KW-1:0]      k;
  logic               step_sat, cmd_step;

  logic [KW-1:0]      knots;
  logic [LW-1:0]      p_lags, q_lags;
  satval_t            sum_v, diff_v, rnd_v;
  logic signed [31:0] add_a, add_b;
  logic signed [65:0] pr;
  logic               out_busy;
  logic [32:0]        n33, end33;
  logic               emit, is_last;

  function automatic logic [AW-1:0] caddr(input sel_e s, input logic [IW-1:0] i);
    return {s, i};
  endfunction

  sna_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.coef_value),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign knots  = (int'(cfg.knots_used) > MAX_KNOTS) ? KW'(MAX_KNOTS) : KW'(cfg.knots_used);
  assign p_lags = (int'(cfg.news_lags) > MAX_NEWS_LAGS) ? LW'(MAX_NEWS_LAGS)
                                                        : LW'(cfg.news_lags);
  assign q_lags = (int'(cfg.mean_lags) > MAX_MEAN_LAGS) ? LW'(MAX_MEAN_LAGS)
                                                        : LW'(cfg.mean_lags);

  assign accept    = in_ch.valid && in_ch.ready;
  assign ram_waddr = caddr(sel_e'(in_ch.table_select), IW'(in_ch.table_index));
  assign ram_we    = accept && (cmd_e'(in_ch.command) == CMD_WRITE) && wr_ok;

  always_comb begin
    unique case (sel_e'(in_ch.table_select))
      SEL_SLOPE: wr_ok = int'(in_ch.table_index) <= MAX_KNOTS;
      SEL_BREAK: wr_ok = int'(in_ch.table_index) < MAX_KNOTS;
      SEL_LAGW:  wr_ok = int'(in_ch.table_index) + 1 < MAX_NEWS_LAGS;
      SEL_MEANW: wr_ok = int'(in_ch.table_index) < MAX_MEAN_LAGS;
      default:   wr_ok = 1'b0;
    endcase
  end

  assign add_a  = (state == ST_NEWS_K_DONE) ? acc : mu;
  assign add_b  = (state == ST_LAG_W) ? acc : mres;
  assign sum_v  = qadd(add_a, add_b);
  assign diff_v = qsub(x, rdata);
  assign pr     = 66'(prod) + (66'sd1 <<< (FRAC_BITS - 1));
  assign rnd_v  = sat_to32(pr >>> FRAC_BITS);

  assign out_busy = out_ch.valid && !out_ch.ready;
  assign n33      = {1'b0, sample_cnt};
  assign end33    = {1'b0, cfg.burn_length} + {1'b0, cfg.total_samples};
  assign emit     = (sample_cnt >= cfg.burn_length) && (n33 < end33);
  assign is_last  = (n33 + 33'd1) == end33;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ram_raddr   = '0;
    in_ch.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          unique case (cmd_e'(in_ch.command))
            CMD_PRIME: state_next = ST_EMIT;
            CMD_STEP:  state_next = ST_LAG_START;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LAG_START: begin
        if (j >= p_lags) begin
          state_next = ST_MEAN_START;
        end else begin
          ram_raddr  = caddr(SEL_SLOPE, '0);
          state_next = ST_S0_WAIT;
        end
      end
      ST_S0_WAIT:     state_next = ST_MUL;
      ST_MUL:         state_next = ST_RND;
      ST_RND:         state_next = ret;
      ST_NEWS0_DONE:  state_next = ST_KNOT_TEST;
      ST_KNOT_TEST: begin
        if (k > knots) begin
          state_next = ST_LAG_W;
        end else begin
          ram_raddr  = caddr(SEL_BREAK, IW'(k - KW'(1)));
          state_next = ST_BP_WAIT;
        end
      end
      ST_BP_WAIT: begin
        if (x > rdata) begin
          ram_raddr  = caddr(SEL_SLOPE, IW'(k));
          state_next = ST_SLOPE_WAIT;
        end else begin
          state_next = ST_LAG_W;
        end
      end
      ST_SLOPE_WAIT:  state_next = ST_MUL;
      ST_NEWS_K_DONE: state_next = ST_KNOT_TEST;
      ST_LAG_W: begin
        if (j == '0) begin
          state_next = ST_LAG_START;
        end else begin
          ram_raddr  = caddr(SEL_LAGW, IW'(j - LW'(1)));
          state_next = ST_LW_WAIT;
        end
      end
      ST_LW_WAIT:     state_next = ST_MUL;
      ST_LAG_DONE:    state_next = ST_LAG_START;
      ST_MEAN_START: begin
        if (j >= q_lags) begin
          state_next = ST_FINAL;
        end else begin
          ram_raddr  = caddr(SEL_MEANW, IW'(j));
          state_next = ST_MW_WAIT;
        end
      end
      ST_MW_WAIT:     state_next = ST_MUL;
      ST_MEAN_DONE:   state_next = ST_MEAN_START;
      ST_FINAL:       state_next = ST_MUL;
      ST_DUR:         state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ret        <= ST_IDLE;
      j          <= '0;
      k          <= '0;
      step_sat   <= 1'b0;
      cmd_step   <= 1'b0;
      sample_cnt <= '0;
      for (int i = 0; i < MAX_NEWS_LAGS; i++) begin
        ehist[i] <= '0;
      end
      for (int i = 0; i < MH_D; i++) begin
        mhist[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            e_reg    <= in_ch.innovation;
            step_sat <= 1'b0;
            j        <= '0;
            if (cmd_e'(in_ch.command) == CMD_PRIME) begin
              mu       <= in_ch.start_mu;
              dur      <= in_ch.start_x;
              cmd_step <= 1'b0;
            end else begin
              mu       <= cfg.base_level;
              cmd_step <= 1'b1;
            end
          end
        end
        ST_LAG_START: begin
          if (j >= p_lags) begin
            j <= '0;
          end else begin
            x <= ehist[j[EHW-1:0]];
          end
        end
        ST_S0_WAIT: begin
          mul_a <= rdata;
          mul_b <= x;
          ret   <= ST_NEWS0_DONE;
        end
        ST_MUL: prod <= mul_a * mul_b;
        ST_RND: begin
          mres <= rnd_v.val;
          if (rnd_v.sat) step_sat <= 1'b1;
        end
        ST_NEWS0_DONE: begin
          acc <= mres;
          k   <= KW'(1);
        end
        ST_BP_WAIT: begin
          if (x > rdata) begin
            mul_b <= diff_v.val;
            if (diff_v.sat) step_sat <= 1'b1;
          end
        end
        ST_SLOPE_WAIT: begin
          mul_a <= rdata;
          ret   <= ST_NEWS_K_DONE;
        end
        ST_NEWS_K_DONE: begin
          acc <= sum_v.val;
          if (sum_v.sat) step_sat <= 1'b1;
          k <= k + KW'(1);
        end
        ST_LAG_W: begin
          if (j == '0) begin
            mu <= sum_v.val;
            if (sum_v.sat) step_sat <= 1'b1;
            j <= j + LW'(1);
          end
        end
        ST_LW_WAIT: begin
          mul_a <= acc;
          mul_b <= rdata;
          ret   <= ST_LAG_DONE;
        end
        ST_LAG_DONE, ST_MEAN_DONE: begin
          mu <= sum_v.val;
          if (sum_v.sat) step_sat <= 1'b1;
          j <= j + LW'(1);
        end
        ST_MW_WAIT: begin
          mul_a <= rdata;
          mul_b <= mhist[j[MHW-1:0]];
          ret   <= ST_MEAN_DONE;
        end
        ST_FINAL: begin
          mul_a <= mu;
          mul_b <= e_reg;
          ret   <= ST_DUR;
        end
        ST_DUR: dur <= mres;
        ST_EMIT: begin
          if (!out_busy) begin
            for (int i = MAX_NEWS_LAGS - 1; i > 0; i--) begin
              ehist[i] <= ehist[i-1];
            end
            ehist[0] <= e_reg;
            for (int i = MH_D - 1; i > 0; i--) begin
              mhist[i] <= mhist[i-1];
            end
            mhist[0] <= mu;
            if (sample_cnt != 32'hffffffff) begin
              sample_cnt <= sample_cnt + 32'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_EMIT && !out_busy && emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !out_busy && emit) begin
      out_ch.duration  <= dur;
      out_ch.saturated <= cmd_step && step_sat;
      out_ch.last      <= is_last;
    end
  end

`ifndef SYNTH
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_EMIT)
    else $error("result word raised outside the emit state");

  a_knot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KNOT_TEST) |-> (int'(k) <= int'(knots) + 1) && (k != '0))
    else $error("knot counter out of range");

  a_rnd_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RND) |-> $past(state) == ST_MUL)
    else $error("rounding stage entered without a product");

  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LW_WAIT || state == ST_S0_WAIT) |-> j < p_lags)
    else $error("news lag index past the lag count");
`endif

endmodule

// ===== hdl/spline_news_acd_filter_top.sv =====
// Top level of the spline news ACD filter: configuration registers and core.
// A write item is stored in the coefficient RAM as it is accepted; a prime item goes straight
// to the emit state. A step item walks each news lag (the slope 0 product, then one product per
// knot passed until a breakpoint ends the walk, then a lag-weight product for each lag after the
// first), then one product per mean lag and the final product, all through the single shared multiplier.
// One item is in work at a time. Reset clears registers, histories and the sample counter.
module spline_news_acd_filter_top #(
  parameter int MAX_KNOTS     = sna_pkg::MAX_KNOTS_DEF,
  parameter int MAX_NEWS_LAGS = sna_pkg::MAX_NEWS_LAGS_DEF,
  parameter int MAX_MEAN_LAGS = sna_pkg::MAX_MEAN_LAGS_DEF,
  parameter int FRAC_BITS     = sna_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sna_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  sna_in_if.sink                      in_ch,
  sna_out_if.source                   out_ch
);
  import sna_pkg::*;

  cfg_t cfg;

  sna_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sna_core #(
    .MAX_KNOTS     (MAX_KNOTS),
    .MAX_NEWS_LAGS (MAX_NEWS_LAGS),
    .MAX_MEAN_LAGS (MAX_MEAN_LAGS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the spline news ACD filter top level.
`timescale 1ns / 100ps

module testbench;
  import sna_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 1000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  sel;
    logic [4:0]  idx;
    logic [31:0] coef;
    logic [31:0] innov;
    logic [31:0] mu;
    logic [31:0] x;
  } item_t;

  typedef struct {
    logic [31:0] dur;
    bit          sat;
    bit          last;
  } word_t;

  typedef struct {
    item_t it;
    bit    typed;
    word_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sna_in_if in_ch ();
  sna_out_if out_ch ();

  spline_news_acd_filter_top uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] slope_m [0:16];
  logic signed [31:0] bp_m [0:15];
  logic signed [31:0] lagw_m [0:6];
  logic signed [31:0] meanw_m [0:7];
  logic signed [31:0] ehist_m [0:7];
  logic signed [31:0] mhist_m [0:7];
  logic [31:0] count_m;
  logic signed [31:0] base_m;
  logic [31:0] burn_m, total_m;
  logic [4:0] knots_m;
  logic [3:0] news_m, mean_m;

  word_t durations_q[$];
  int errors = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  function automatic void report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endfunction

  function automatic logic signed [31:0] fx_sat(longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(logic signed [31:0] a, logic signed [31:0] b,
                                                inout bit s);
    return fx_sat(longint'(a) + longint'(b), s);
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b,
                                                inout bit s);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return fx_sat(p >>> 16, s);
  endfunction

  function automatic logic signed [31:0] spline_news(logic signed [31:0] x, int knots,
                                                     inout bit s);
    logic signed [31:0] acc;
    logic signed [31:0] d;
    acc = fx_mul(slope_m[0], x, s);
    for (int k = 1; k <= knots; k++) begin
      if (x > bp_m[k-1]) begin
        d = fx_sat(longint'(x) - longint'(bp_m[k-1]), s);
        acc = fx_add(acc, fx_mul(slope_m[k], d, s), s);
      end else begin
        break;
      end
    end
    return acc;
  endfunction

  // Updates the mirrored state for one accepted word and returns 1 if a result is due.
  function automatic bit predict_duration(item_t it, output word_t w);
    bit s;
    logic signed [31:0] mu, h, dur;
    int knots, p, q;
    logic [32:0] endv;
    logic [31:0] n;
    s = 1'b0;
    w = '{default: 0};
    if (it.cmd == CMD_WRITE) begin
      case (it.sel)
        SEL_SLOPE: if (it.idx <= 16) slope_m[it.idx] = it.coef;
        SEL_BREAK: if (it.idx < 16) bp_m[it.idx] = it.coef;
        SEL_LAGW:  if (it.idx < 7) lagw_m[it.idx] = it.coef;
        default:   if (it.idx < 8) meanw_m[it.idx] = it.coef;
      endcase
      return 1'b0;
    end
    if (it.cmd == CMD_NONE) return 1'b0;
    if (it.cmd == CMD_PRIME) begin
      dur = it.x;
      mu = it.mu;
    end else begin
      knots = knots_m > 16 ? 16 : knots_m;
      p = news_m > 8 ? 8 : news_m;
      q = mean_m > 8 ? 8 : mean_m;
      mu = base_m;
      for (int j = 0; j < p; j++) begin
        h = spline_news(ehist_m[j], knots, s);
        if (j > 0) h = fx_mul(h, lagw_m[j-1], s);
        mu = fx_add(mu, h, s);
      end
      for (int j = 0; j < q; j++) mu = fx_add(mu, fx_mul(meanw_m[j], mhist_m[j], s), s);
      dur = fx_mul(mu, it.innov, s);
    end
    for (int j = 7; j > 0; j--) begin
      ehist_m[j] = ehist_m[j-1];
      mhist_m[j] = mhist_m[j-1];
    end
    ehist_m[0] = it.innov;
    mhist_m[0] = mu;
    n = count_m;
    if (count_m != 32'hffffffff) count_m++;
    endv = {1'b0, burn_m} + {1'b0, total_m};
    if (!(n >= burn_m && {1'b0, n} < endv)) return 1'b0;
    w.dur = dur;
    w.sat = (it.cmd == CMD_STEP) && s;
    w.last = ({1'b0, n} + 33'd1 == endv);
    return 1'b1;
  endfunction

  task automatic cfg_write(reg_e r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_BASE_LEVEL:    base_m = v;
      REG_BURN_LENGTH:   burn_m = v;
      REG_TOTAL_SAMPLES: total_m = v;
      REG_KNOTS_USED:    knots_m = v[4:0];
      REG_NEWS_LAGS:     news_m = v[3:0];
      default:           mean_m = v[3:0];
    endcase
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] burn, logic [31:0] total,
                           logic [4:0] knots, logic [3:0] news, logic [3:0] mean);
    cfg_write(REG_BASE_LEVEL, base);
    cfg_write(REG_BURN_LENGTH, burn);
    cfg_write(REG_TOTAL_SAMPLES, total);
    cfg_write(REG_KNOTS_USED, 32'(knots));
    cfg_write(REG_NEWS_LAGS, 32'(news));
    cfg_write(REG_MEAN_LAGS, 32'(mean));
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A word is offered after the gap and held until the handshake; valid stays high
  // past acceptance so that back-to-back words need no second assignment.
  task automatic send(item_t it, bit typed, word_t want);
    word_t w;
    bit due;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.cmd;
    in_ch.table_select <= it.sel;
    in_ch.table_index <= it.idx;
    in_ch.coef_value <= it.coef;
    in_ch.innovation <= it.innov;
    in_ch.start_mu <= it.mu;
    in_ch.start_x <= it.x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = predict_duration(it, w);
    if (typed) w = want;
    if (due || typed) durations_q.push_back(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (durations_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near_zero(int r);
    return 32'($urandom_range(0, 2 * r) - r);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    it.cmd = CMD_STEP;
    it.sel = 2'($urandom_range(0, 3));
    it.idx = 5'($urandom_range(0, 31));
    it.coef = $urandom();
    it.innov = ($urandom_range(0, 9) < 7) ? near_zero(524288) : $urandom();
    it.mu = ($urandom_range(0, 3) == 0) ? $urandom() : near_zero(262144);
    it.x = $urandom();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.cmd = CMD_WRITE;
      case (it.sel)
        SEL_SLOPE: it.idx = 5'($urandom_range(0, 16));
        SEL_BREAK: it.idx = 5'($urandom_range(0, 15));
        SEL_LAGW:  it.idx = 5'($urandom_range(0, 6));
        default:   it.idx = 5'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 4) != 0) it.coef = near_zero(it.sel == SEL_MEANW ? 6554 : 65536);
    end else if (r < 11) begin
      it.cmd = CMD_WRITE;
    end else if (r < 14) begin
      it.cmd = CMD_NONE;
    end else if (r < 28) begin
      it.cmd = CMD_PRIME;
    end
    return it;
  endfunction

  row_t dir_tab[] = '{
    '{'{CMD_PRIME, SEL_SLOPE, 5'd0, 32'h0, 32'h00010000, 32'h00020000, 32'h80000000},
      1'b1, '{32'h80000000, 1'b0, 1'b0}},
    '{'{CMD_PRIME, SEL_SLOPE, 5'd0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
      1'b1, '{32'h7fffffff, 1'b0, 1'b0}},
    '{'{CMD_NONE, SEL_MEANW, 5'd31, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_SLOPE, 5'd31, 32'hffffffff, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_BREAK, 5'd16, 32'h7fffffff, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_LAGW, 5'd7, 32'h80000000, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_MEANW, 5'd8, 32'h7fffffff, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h7fffffff, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h80000000, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h00000001, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'hffffffff, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'hfffd8000, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h00038001, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_SLOPE, 5'd0, 32'h7fffffff, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h7fffffff, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_SLOPE, 5'd0, 32'h00010000, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_LAGW, 5'd6, 32'h80000000, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h00020000, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_LAGW, 5'd6, 32'h00008000, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_PRIME, SEL_SLOPE, 5'd0, 32'h0, 32'h80000000, 32'h80000000, 32'h0},
      1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'h00020000, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_MEANW, 5'd7, 32'h7fffffff, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_STEP, SEL_SLOPE, 5'd0, 32'h0, 32'hfff00000, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, SEL_MEANW, 5'd7, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, '{32'h0, 1'b0, 1'b0}}
  };

  always @(posedge clk) begin
    word_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (durations_q.size() == 0) begin
        report($sformatf("unexpected word duration=%h", out_ch.duration));
      end else begin
        w = durations_q.pop_front();
        if (out_ch.duration !== w.dur)
          report($sformatf("duration %h, wanted %h", out_ch.duration, w.dur));
        if (out_ch.saturated !== w.sat)
          report($sformatf("saturated %b, wanted %b", out_ch.saturated, w.sat));
        if (out_ch.last !== w.last)
          report($sformatf("last %b, wanted %b", out_ch.last, w.last));
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (2500) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ch.ready <= !rst;
      end
    end
  end

  initial begin
    #60000000;
    $display("** spline_news_acd_filter_top: FAILED **");
    $finish;
  end

  initial begin
    item_t it;
    word_t none;
    logic [31:0] burn, total, base;
    logic [4:0] knots;
    logic [3:0] news, mean;
    int n_items;
    none = '{default: 0};
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.table_select = SEL_SLOPE;
    in_ch.table_index = '0;
    in_ch.coef_value = '0;
    in_ch.innovation = '0;
    in_ch.start_mu = '0;
    in_ch.start_x = '0;
    for (int j = 0; j < 8; j++) begin
      ehist_m[j] = '0;
      mhist_m[j] = '0;
    end
    count_m = '0;
    base_m = '0;
    burn_m = '0;
    total_m = '0;
    knots_m = '0;
    news_m = 4'd1;
    mean_m = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(32'h0, 32'h0, 32'hffffffff, 5'd16, 4'd8, 4'd8);
    // Every coefficient entry is loaded before any step can read it.
    for (int k = 0; k <= 16; k++)
      send('{CMD_WRITE, SEL_SLOPE, 5'(k), near_zero(65536), 32'h0, 32'h0, 32'h0}, 1'b0, none);
    for (int k = 0; k < 16; k++)
      send('{CMD_WRITE, SEL_BREAK, 5'(k), 32'(-262144 + k * 32768), 32'h0, 32'h0, 32'h0},
           1'b0, none);
    for (int k = 0; k < 7; k++)
      send('{CMD_WRITE, SEL_LAGW, 5'(k), near_zero(32768), 32'h0, 32'h0, 32'h0}, 1'b0, none);
    for (int k = 0; k < 8; k++)
      send('{CMD_WRITE, SEL_MEANW, 5'(k), near_zero(6554), 32'h0, 32'h0, 32'h0}, 1'b0, none);
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      base = near_zero(131072);
      knots = 5'($urandom_range(0, 6));
      news = 4'($urandom_range(1, 8));
      mean = 4'($urandom_range(0, 4));
      burn = count_m + $urandom_range(0, 5);
      total = $urandom_range(20, 60);
      n_items = 75;
      case (ph)
        0: begin
          base = 32'h80000000;
          knots = 5'd0;
          news = 4'd0;
          mean = 4'd0;
        end
        1: begin
          base = 32'h7fffffff;
          knots = 5'd31;
          news = 4'd15;
          mean = 4'd15;
        end
        2: begin
          knots = 5'd16;
          total = 32'hffffffff;
          hold_req = 1'b1;
        end
        3: begin
          burn = 32'hffffffff;
          total = 32'hffffffff;
          n_items = 20;
        end
        4: begin
          burn = 32'h0;
          total = 32'hffffffff;
        end
        5: begin
          burn = 32'h0;
          total = 32'h0;
          n_items = 20;
        end
        6: quiet = 1'b1;
        default: ;
      endcase
      configure(base, burn, total, knots, news, mean);
      for (int i = 0; i < n_items; i++) begin
        it = random_item();
        send(it, 1'b0, none);
      end
      drain();
      quiet = 1'b0;
    end

    if (errors == 0) begin
      $display("** spline_news_acd_filter_top: PASSED **");
    end else begin
      $display("** spline_news_acd_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sna_pkg.sv
hdl/sna_ifs.sv
hdl/sna_ram.sv
hdl/sna_regs.sv
hdl/sna_core.sv
hdl/spline_news_acd_filter_top.sv
verif/testbench.sv
